[design/vrnu_pkg.sv]
package vrnu_pkg;

  // column size defaults
  localparam int COLUMN_SIDE_DEF   = 16;
  localparam int COLUMN_HEIGHT_DEF = 128;

  // nibble unpacking
  localparam int NIBBLE_BITS = 4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_X_FIRST = 3'd0;
  localparam logic [2:0] REG_X_STOP  = 3'd1;
  localparam logic [2:0] REG_Y_FIRST = 3'd2;
  localparam logic [2:0] REG_Y_STOP  = 3'd3;
  localparam logic [2:0] REG_Z_FIRST = 3'd4;
  localparam logic [2:0] REG_Z_STOP  = 3'd5;

  // field kinds, also the stream sections in order
  localparam logic [1:0] KIND_ID    = 2'd0;
  localparam logic [1:0] KIND_META  = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;
  localparam logic [1:0] KIND_SKY   = 2'd3;

  // region bounds
  typedef struct packed {
    logic [3:0] x_first;
    logic [4:0] x_stop;
    logic [6:0] y_first;
    logic [7:0] y_stop;
    logic [3:0] z_first;
    logic [4:0] z_stop;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_first: 4'd0, x_stop: 5'd16,
    y_first: 7'd0, y_stop: 8'd128,
    z_first: 4'd0, z_stop: 5'd16
  };

  // current walk position, as wide as the largest stop allows
  typedef struct packed {
    logic [1:0] section;
    logic [4:0] x;
    logic [7:0] y;
    logic [4:0] z;
    logic       finished;
  } walk_t;

  // outcome of stepping past the current cell
  typedef struct packed {
    logic ended;     // section ended with this cell
    logic done;      // region complete after this cell
  } adv_t;

endpackage

[design/vrnu_walker.sv]
module vrnu_walker #(
  parameter int COLUMN_SIDE   = vrnu_pkg::COLUMN_SIDE_DEF,
  parameter int COLUMN_HEIGHT = vrnu_pkg::COLUMN_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  vrnu_pkg::cfg_t  cfg,       // bounds in force
  input  vrnu_pkg::cfg_t  cfg_load,  // bounds to restart with
  input  logic            restart,
  input  logic            step,
  output vrnu_pkg::walk_t cur,
  output vrnu_pkg::adv_t  adv
);

  vrnu_pkg::walk_t walk;
  vrnu_pkg::walk_t walk_next;
  vrnu_pkg::walk_t walk_start;

  logic [4:0] xs, xs_load;
  logic [7:0] ys, ys_load;
  logic [4:0] zs, zs_load;
  logic [7:0] y_inc;
  logic [4:0] z_inc;
  logic [4:0] x_inc;

  // clamp stops to the column
  always_comb begin
    xs      = (32'(cfg.x_stop) > COLUMN_SIDE) ? 5'(COLUMN_SIDE) : cfg.x_stop;
    ys      = (32'(cfg.y_stop) > COLUMN_HEIGHT) ? 8'(COLUMN_HEIGHT) : cfg.y_stop;
    zs      = (32'(cfg.z_stop) > COLUMN_SIDE) ? 5'(COLUMN_SIDE) : cfg.z_stop;
    xs_load = (32'(cfg_load.x_stop) > COLUMN_SIDE) ? 5'(COLUMN_SIDE) : cfg_load.x_stop;
    ys_load = (32'(cfg_load.y_stop) > COLUMN_HEIGHT) ? 8'(COLUMN_HEIGHT)
                                                     : cfg_load.y_stop;
    zs_load = (32'(cfg_load.z_stop) > COLUMN_SIDE) ? 5'(COLUMN_SIDE) : cfg_load.z_stop;
  end

  // start of a fresh walk
  always_comb begin
    walk_start.section  = vrnu_pkg::KIND_ID;
    walk_start.x        = {1'b0, cfg_load.x_first};
    walk_start.y        = {1'b0, cfg_load.y_first};
    walk_start.z        = {1'b0, cfg_load.z_first};
    walk_start.finished = (xs_load <= {1'b0, cfg_load.x_first}) ||
                          (ys_load <= {1'b0, cfg_load.y_first}) ||
                          (zs_load <= {1'b0, cfg_load.z_first});
  end

  // step to the next cell, y innermost then z then x
  always_comb begin
    walk_next = walk;
    adv.ended = 1'b0;
    y_inc     = walk.y + 8'd1;
    z_inc     = walk.z + 5'd1;
    x_inc     = walk.x + 5'd1;
    if (y_inc < ys) begin
      walk_next.y = y_inc;
    end else begin
      walk_next.y = {1'b0, cfg.y_first};
      if (z_inc < zs) begin
        walk_next.z = z_inc;
      end else begin
        walk_next.z = {1'b0, cfg.z_first};
        if (x_inc < xs) begin
          walk_next.x = x_inc;
        end else begin
          walk_next.x = {1'b0, cfg.x_first};
          adv.ended   = 1'b1;
          if (walk.section == vrnu_pkg::KIND_SKY) begin
            walk_next.finished = 1'b1;
          end else begin
            walk_next.section = walk.section + 2'd1;
          end
        end
      end
    end
    adv.done = walk_next.finished;
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      walk <= walk_start;
    end else if (step) begin
      walk <= walk_next;
    end
  end

  assign cur = walk;

endmodule

[design/voxel_region_nibble_unpacker.sv]
// Voxel region nibble unpacker
// Input stream s_*: one byte of the decompressed region stream per request,
// first an id byte for every cell, then metadata, block light and sky light
// packed two nibbles per byte, low nibble first. Cells are walked with x
// outermost, then z, then y.
// Output stream m_*: one cell write per request, the field kind in m_tuser
// and tlast on the final write of the region. Bytes after the region is
// complete are taken and dropped.
// Path: a byte is registered in the input register, and each write made from
// it is registered in the output register before it appears on m_*.
// Throughput: one write per cycle unless m_tready stalls, set by the single
// output register; an id byte gives one write, a nibble byte up to two.
// Config: cfg_we/cfg_index/cfg_data write a bound and restart the walk; only
// write while the block is idle.
// Reset clears both stages, loads the full column as region and restarts.
// When m_tready is low the write waits in the output register, the held byte
// waits behind it and s_tready drops.
module voxel_region_nibble_unpacker #(
  parameter int COLUMN_SIDE   = vrnu_pkg::COLUMN_SIDE_DEF,
  parameter int COLUMN_HEIGHT = vrnu_pkg::COLUMN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // stream_byte[7:0]
  // cell writes out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cell_x[3:0], cell_y[10:4], cell_z[14:11],
                                 // field_value[22:15], zero[23]
  output logic [1:0]  m_tuser,   // field_kind[1:0]
  output logic        m_tlast    // region_done
);

  vrnu_pkg::cfg_t  cfg;
  vrnu_pkg::cfg_t  cfg_next;
  vrnu_pkg::walk_t cur;
  vrnu_pkg::adv_t  adv;
  logic            restart;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_phase;

  logic       out_valid;
  logic [1:0] out_kind;
  logic [3:0] out_x;
  logic [6:0] out_y;
  logic [3:0] out_z;
  logic [7:0] out_value;
  logic       out_last;

  logic       out_free;
  logic       emit;
  logic       release_byte;
  logic [7:0] value;

  // register write decode
  always_comb begin
    cfg_next = cfg;
    restart  = 1'b0;
    if (rst) begin
      cfg_next = vrnu_pkg::CFG_RESET;
    end else if (cfg_we) begin
      restart = 1'b1;
      case (cfg_index)
        vrnu_pkg::REG_X_FIRST: cfg_next.x_first = cfg_data[3:0];
        vrnu_pkg::REG_X_STOP:  cfg_next.x_stop  = cfg_data[4:0];
        vrnu_pkg::REG_Y_FIRST: cfg_next.y_first = cfg_data[6:0];
        vrnu_pkg::REG_Y_STOP:  cfg_next.y_stop  = cfg_data;
        vrnu_pkg::REG_Z_FIRST: cfg_next.z_first = cfg_data[3:0];
        vrnu_pkg::REG_Z_STOP:  cfg_next.z_stop  = cfg_data[4:0];
        default:               restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

  vrnu_walker #(
    .COLUMN_SIDE   (COLUMN_SIDE),
    .COLUMN_HEIGHT (COLUMN_HEIGHT)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_load (cfg_next),
    .restart  (restart),
    .step     (emit),
    .cur      (cur),
    .adv      (adv)
  );

  // write selection from the held byte
  always_comb begin
    out_free     = !out_valid || m_tready;
    emit         = hold_valid && !cur.finished && out_free;
    release_byte = 1'b0;
    if (hold_valid) begin
      if (cur.finished) begin
        release_byte = 1'b1;
      end else if (out_free) begin
        release_byte = (cur.section == vrnu_pkg::KIND_ID) || hold_phase || adv.ended;
      end
    end
    if (cur.section == vrnu_pkg::KIND_ID) begin
      value = hold_byte;
    end else if (hold_phase) begin
      value = {4'd0, hold_byte[7:vrnu_pkg::NIBBLE_BITS]};
    end else begin
      value = {4'd0, hold_byte[vrnu_pkg::NIBBLE_BITS-1:0]};
    end
  end

  assign s_tready = !hold_valid || release_byte;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_phase <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
      hold_phase <= 1'b0;
    end else if (release_byte) begin
      hold_valid <= 1'b0;
      hold_phase <= 1'b0;
    end else if (emit) begin
      hold_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_byte <= s_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= cur.section;
      out_x     <= cur.x[3:0];
      out_y     <= cur.y[6:0];
      out_z     <= cur.z[3:0];
      out_value <= value;
      out_last  <= adv.done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_value, out_z, out_y, out_x};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule
